@@ hdl/u8u16_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8u16_pkg
// Types and constants shared by the UTF-8 to UTF-16 decoder.
// ----------------------------------------------------------------------------
package u8u16_pkg;

   localparam int unsigned MAX_UNITS = 4;

   localparam logic [15:0] REPL_UNIT     = 16'hFFFD;
   localparam logic [15:0] HI_SURR_BASE  = 16'hD800;
   localparam logic [15:0] LO_SURR_BASE  = 16'hDC00;
   localparam logic [20:0] SURR_FIRST    = 21'h00D800;
   localparam logic [20:0] SURR_LAST     = 21'h00DFFF;
   localparam logic [20:0] MAX_POINT     = 21'h10FFFF;
   localparam logic [20:0] PLANE1_BASE   = 21'h010000;
   localparam logic [20:0] MIN_LEN2      = 21'h000080;
   localparam logic [20:0] MIN_LEN3      = 21'h000800;
   localparam logic [20:0] MIN_LEN4      = 21'h010000;

   localparam logic [2:0] LEN_IDLE = 3'd0;
   localparam logic [2:0] LEN2     = 3'd2;
   localparam logic [2:0] LEN3     = 3'd3;
   localparam logic [2:0] LEN4     = 3'd4;

   typedef struct packed {
      logic [20:0] point;
      logic [2:0]  exp_len;
      logic [2:0]  seen;
   } seq_state_type;

   typedef struct packed {
      logic [MAX_UNITS-1:0][15:0] units;
      logic [2:0]                 cnt;
      seq_state_type              next_state;
   } dec_out_type;

endpackage

@@ hdl/u8u16_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8u16 channel interfaces
// Valid/ready channels for UTF-8 bytes in and UTF-16 code units out.
// ----------------------------------------------------------------------------
interface u8u16_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] text_byte;
   logic       final_byte;

   modport source (output valid, output text_byte, output final_byte, input ready);
   modport sink   (input valid, input text_byte, input final_byte, output ready);
endinterface

interface u8u16_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] code_unit;
   logic        run_end;
   logic        text_end;

   modport source (output valid, output code_unit, output run_end, output text_end,
                   input ready);
   modport sink   (input valid, input code_unit, input run_end, input text_end,
                   output ready);
endinterface

@@ hdl/utf8_to_utf16_decoder.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_to_utf16_decoder
// Streaming UTF-8 to UTF-16 transcoder; each invalid byte becomes U+FFFD.
//
//   channel | dir | payload                          | transaction
//   req     | in  | text_byte[7:0], final_byte       | one UTF-8 byte
//   rsp     | out | code_unit[15:0], run_end, text_end | one UTF-16 code unit
//
// A byte is registered, decoded and its units (0 to 4) land in a result
// register that drains one unit per cycle while rsp is ready. One byte per
// cycle while each gives at most one unit and rsp is ready; more units hold
// the input till drained. Bytes giving no unit pass even while results wait.
// Reset is synchronous and clears the pending sequence and all valids.
// ----------------------------------------------------------------------------
module utf8_to_utf16_decoder
   import u8u16_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   u8u16_req_if.sink      req_bus,
   u8u16_rsp_if.source    rsp_bus
);

   logic                       s1_valid_ff, s1_valid_in;
   logic [7:0]                 s1_byte_ff;
   logic                       s1_fin_ff;
   seq_state_type              state_ff, state_in;
   logic                       res_valid_ff, res_valid_in;
   logic [MAX_UNITS-1:0][15:0] res_units_ff;
   logic [2:0]                 res_cnt_ff;
   logic [1:0]                 res_idx_ff, res_idx_in;
   logic                       res_fin_ff;

   dec_out_type dec;
   logic        dec_some;
   logic        res_last;
   logic        res_free;
   logic        s1_adv;
   logic        res_load;

   u8u16_decode u_decode (
      .cur_state  (state_ff),
      .text_byte  (s1_byte_ff),
      .final_byte (s1_fin_ff),
      .dec        (dec)
   );

   assign dec_some = (dec.cnt != 3'd0);
   assign res_last = (({1'b0, res_idx_ff} + 3'd1) == res_cnt_ff);
   assign res_free = !res_valid_ff || (rsp_bus.ready && res_last);
   assign s1_adv   = s1_valid_ff && (!dec_some || res_free);
   assign res_load = s1_adv && dec_some;

   assign req_bus.ready     = !s1_valid_ff || s1_adv;
   assign rsp_bus.valid     = res_valid_ff;
   assign rsp_bus.code_unit = res_units_ff[res_idx_ff];
   assign rsp_bus.run_end   = res_last;
   assign rsp_bus.text_end  = res_last && res_fin_ff;

   always_comb begin
      s1_valid_in = req_bus.ready ? req_bus.valid : s1_valid_ff;
      state_in    = s1_adv ? dec.next_state : state_ff;
      res_valid_in = res_valid_ff;
      res_idx_in   = res_idx_ff;
      if (res_load) begin
         res_valid_in = 1'b1;
         res_idx_in   = 2'd0;
      end else if (res_valid_ff && rsp_bus.ready) begin
         if (res_last) begin
            res_valid_in = 1'b0;
         end else begin
            res_idx_in = res_idx_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         state_ff     <= '0;
         res_valid_ff <= 1'b0;
         res_idx_ff   <= 2'd0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         state_ff     <= state_in;
         res_valid_ff <= res_valid_in;
         res_idx_ff   <= res_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_bus.valid && req_bus.ready) begin
         s1_byte_ff <= req_bus.text_byte;
         s1_fin_ff  <= req_bus.final_byte;
      end
      if (res_load) begin
         res_units_ff <= dec.units;
         res_cnt_ff   <= dec.cnt;
         res_fin_ff   <= s1_fin_ff;
      end
   end

   a_res_index: assert property (@(posedge clock) disable iff (reset)
      res_valid_ff |-> (res_cnt_ff != 3'd0) && ({1'b0, res_idx_ff} < res_cnt_ff))
      else $error("result index outside loaded unit count");

   a_seq_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff.exp_len != LEN_IDLE) |->
         (state_ff.seen != 3'd0) && (state_ff.seen < state_ff.exp_len))
      else $error("pending sequence byte count out of range");

   a_final_flush: assert property (@(posedge clock) disable iff (reset)
      (s1_adv && s1_fin_ff) |=> (state_ff.exp_len == LEN_IDLE))
      else $error("sequence still pending after last byte of text");

   a_final_units: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s1_fin_ff) |-> dec_some)
      else $error("last byte of text produced no code unit");

endmodule

@@ hdl/u8u16_decode.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8u16_decode
// One-byte decode step: sequence state plus byte in, code units and next
// sequence state out.
// ----------------------------------------------------------------------------
module u8u16_decode
   import u8u16_pkg::*;
(
   input  seq_state_type cur_state,
   input  logic [7:0]    text_byte,
   input  logic          final_byte,
   output dec_out_type   dec
);

   logic        pending;
   logic        is_cont;
   logic [20:0] pt_sh;
   logic [2:0]  seen_inc;
   logic [20:0] min_point;
   logic        point_ok;
   logic [20:0] cpm;
   logic        has_s;
   logic [1:0]  sidx;
   logic [15:0] sval;
   logic        pair;
   logic [15:0] lo_unit;
   logic [2:0]  k;

   assign pending  = (cur_state.exp_len != LEN_IDLE);
   assign is_cont  = (text_byte[7:6] == 2'b10);
   assign pt_sh    = {cur_state.point[14:0], text_byte[5:0]};
   assign seen_inc = cur_state.seen + 3'd1;
   assign k        = pending ? cur_state.seen : 3'd0;
   assign cpm      = pt_sh - PLANE1_BASE;

   always_comb begin
      case (cur_state.exp_len)
         LEN3:    min_point = MIN_LEN3;
         LEN4:    min_point = MIN_LEN4;
         default: min_point = MIN_LEN2;
      endcase
   end

   assign point_ok = (pt_sh >= min_point) && (pt_sh <= MAX_POINT) &&
                     !((pt_sh >= SURR_FIRST) && (pt_sh <= SURR_LAST));

   always_comb begin
      has_s           = 1'b0;
      sidx            = 2'd0;
      sval            = REPL_UNIT;
      pair            = 1'b0;
      lo_unit         = LO_SURR_BASE + {6'd0, cpm[9:0]};
      dec.cnt         = 3'd0;
      dec.next_state  = '0;
      if (pending && is_cont) begin
         if (seen_inc >= cur_state.exp_len) begin
            if (point_ok) begin
               has_s = 1'b1;
               if (pt_sh >= PLANE1_BASE) begin
                  pair    = 1'b1;
                  sval    = HI_SURR_BASE + {6'd0, cpm[19:10]};
                  dec.cnt = 3'd2;
               end else begin
                  sval    = pt_sh[15:0];
                  dec.cnt = 3'd1;
               end
            end else begin
               dec.cnt = seen_inc;
            end
         end else if (final_byte) begin
            dec.cnt = seen_inc;
         end else begin
            dec.next_state.point   = pt_sh;
            dec.next_state.exp_len = cur_state.exp_len;
            dec.next_state.seen    = seen_inc;
         end
      end else begin
         if (text_byte[7] == 1'b0) begin
            has_s   = 1'b1;
            sidx    = k[1:0];
            sval    = {8'd0, text_byte};
            dec.cnt = k + 3'd1;
         end else if (text_byte[7:5] == 3'b110 || text_byte[7:4] == 4'b1110 ||
                      text_byte[7:3] == 5'b11110) begin
            if (final_byte) begin
               dec.cnt = k + 3'd1;
            end else begin
               dec.cnt          = k;
               dec.next_state.seen = 3'd1;
               if (text_byte[7:5] == 3'b110) begin
                  dec.next_state.point   = {16'd0, text_byte[4:0]};
                  dec.next_state.exp_len = LEN2;
               end else if (text_byte[7:4] == 4'b1110) begin
                  dec.next_state.point   = {17'd0, text_byte[3:0]};
                  dec.next_state.exp_len = LEN3;
               end else begin
                  dec.next_state.point   = {18'd0, text_byte[2:0]};
                  dec.next_state.exp_len = LEN4;
               end
            end
         end else begin
            dec.cnt = k + 3'd1;
         end
      end

      for (int i = 0; i < MAX_UNITS; i++) begin
         if (has_s && sidx == i[1:0]) begin
            dec.units[i] = sval;
         end else if (pair && i == 1) begin
            dec.units[i] = lo_unit;
         end else begin
            dec.units[i] = REPL_UNIT;
         end
      end
   end

endmodule

@@ tb/tb_utf8_to_utf16_decoder.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_utf8_to_utf16_decoder
// Drives UTF-8 bytes into the decoder and checks every UTF-16 code unit,
// with its run_end and text_end flags, against a transcoder model kept in
// the bench. The byte stream opens with hand-picked sequences, then random
// text: mostly well-formed code points of every length, mixed with overlong,
// surrogate, out-of-range and truncated sequences and stray bytes. Both
// channels idle at random, apart from one stretch each with no idling.
// ----------------------------------------------------------------------------
module tb_utf8_to_utf16_decoder
   import u8u16_pkg::*;
();

   typedef struct packed {
      logic [7:0] text_byte;
      logic       final_byte;
   } text_item_type;

   typedef struct packed {
      logic [15:0] code_unit;
      logic        run_end;
      logic        text_end;
   } unit_rec_type;

   logic clock;
   logic reset;

   u8u16_req_if req_bus ();
   u8u16_rsp_if rsp_bus ();

   utf8_to_utf16_decoder DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   text_item_type byte_queue[$];
   unit_rec_type  expected_units[$];
   unit_rec_type  step_units[$];

   logic [20:0] gathered_point = '0;
   logic [2:0]  seq_len        = LEN_IDLE;
   logic [2:0]  seq_seen       = '0;

   int  err_count  = 0;
   int  sent_count = 0;
   int  rcvd_count = 0;
   bit  byte_taken = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #2ms;
      $display("utf8_to_utf16_decoder verification failed");
      $finish;
   end

   // ---------------------------------------------------------------- model
   task automatic emit_unit(input logic [15:0] unit);
      unit_rec_type rec;
      rec = '{unit, 1'b0, 1'b0};
      step_units.insert(step_units.size(), rec);
   endtask

   task automatic flush_pending();
      for (int i = 0; i < seq_seen && i < 4; i++) emit_unit(REPL_UNIT);
      gathered_point = '0;
      seq_len        = LEN_IDLE;
      seq_seen       = '0;
   endtask

   task automatic open_lead(input logic [7:0] b);
      if (b[7] == 1'b0) begin
         emit_unit({8'h00, b});
      end else if (b[7:5] == 3'b110) begin
         gathered_point = {16'h0, b[4:0]};
         seq_len        = LEN2;
         seq_seen       = 3'd1;
      end else if (b[7:4] == 4'b1110) begin
         gathered_point = {17'h0, b[3:0]};
         seq_len        = LEN3;
         seq_seen       = 3'd1;
      end else if (b[7:3] == 5'b11110) begin
         gathered_point = {18'h0, b[2:0]};
         seq_len        = LEN4;
         seq_seen       = 3'd1;
      end else begin
         emit_unit(REPL_UNIT);
      end
   endtask

   task automatic decode_text_byte(input logic [7:0] b, input logic fin);
      logic [20:0] floor_point;
      logic [20:0] offset;
      step_units.delete();
      if (seq_len != LEN_IDLE) begin
         if (b[7:6] == 2'b10) begin
            gathered_point = {gathered_point[14:0], b[5:0]};
            seq_seen       = seq_seen + 3'd1;
            if (seq_seen >= seq_len) begin
               floor_point = (seq_len == LEN3) ? MIN_LEN3 :
                             (seq_len == LEN4) ? MIN_LEN4 : MIN_LEN2;
               if (gathered_point < floor_point || gathered_point > MAX_POINT ||
                   (gathered_point >= SURR_FIRST && gathered_point <= SURR_LAST)) begin
                  flush_pending();
               end else begin
                  if (gathered_point < PLANE1_BASE) begin
                     emit_unit(gathered_point[15:0]);
                  end else begin
                     offset = gathered_point - PLANE1_BASE;
                     emit_unit(HI_SURR_BASE + {6'h0, offset[19:10]});
                     emit_unit(LO_SURR_BASE + {6'h0, offset[9:0]});
                  end
                  gathered_point = '0;
                  seq_len        = LEN_IDLE;
                  seq_seen       = '0;
               end
            end
         end else begin
            flush_pending();
            open_lead(b);
         end
      end else begin
         open_lead(b);
      end
      if (fin && seq_len != LEN_IDLE) flush_pending();
      if (step_units.size() > 0) begin
         step_units[step_units.size()-1].run_end  = 1'b1;
         step_units[step_units.size()-1].text_end = fin;
      end
      foreach (step_units[i]) expected_units.insert(expected_units.size(), step_units[i]);
   endtask

   // ------------------------------------------------------------- stimulus
   task automatic push_byte(input logic [7:0] b, input logic fin);
      text_item_type item;
      item = '{b, fin};
      byte_queue.insert(byte_queue.size(), item);
   endtask

   task automatic push_seq(input logic [20:0] cp, input int len, input int cut);
      logic [7:0]  lead;
      logic [20:0] shifted;
      logic        fin;
      case (len)
         1:       lead = {1'b0, cp[6:0]};
         2:       lead = {3'b110, cp[10:6]};
         3:       lead = {4'b1110, cp[15:12]};
         default: lead = {5'b11110, cp[20:18]};
      endcase
      fin = (cut == 1) && ($urandom_range(15) == 0);
      push_byte(lead, fin);
      for (int k = 1; k < cut; k++) begin
         shifted = cp >> (6 * (len - 1 - k));
         fin     = (k == cut - 1) && ($urandom_range(15) == 0);
         push_byte({2'b10, shifted[5:0]}, fin);
      end
   endtask

   initial begin
      int          pick;
      int          len;
      int          kind;
      logic [20:0] cp;

      reset = 1'b1;

      // directed: ASCII extremes, longest valid forms, bad forms, cut text
      push_byte(8'h00, 1'b0);
      push_byte(8'h7F, 1'b0);
      push_byte(8'hC2, 1'b0); push_byte(8'h80, 1'b0);
      push_byte(8'hEF, 1'b0); push_byte(8'hBF, 1'b0); push_byte(8'hBF, 1'b0);
      push_byte(8'hF4, 1'b0); push_byte(8'h8F, 1'b0);
      push_byte(8'hBF, 1'b0); push_byte(8'hBF, 1'b0);
      push_byte(8'hED, 1'b0); push_byte(8'hA0, 1'b0); push_byte(8'h80, 1'b0);
      push_byte(8'hF4, 1'b0); push_byte(8'h90, 1'b0);
      push_byte(8'h80, 1'b0); push_byte(8'h80, 1'b0);
      push_byte(8'hC0, 1'b0); push_byte(8'h80, 1'b0);
      push_byte(8'h80, 1'b0);
      push_byte(8'hFF, 1'b0);
      push_byte(8'hF8, 1'b0);
      push_byte(8'hC3, 1'b0); push_byte(8'h41, 1'b0);
      push_byte(8'hE2, 1'b0); push_byte(8'h82, 1'b1);
      push_byte(8'h41, 1'b1);

      while (byte_queue.size() < 480) begin
         pick = $urandom_range(99);
         if (pick < 65) begin
            len = $urandom_range(1, 4);
            case (len)
               1:       cp = 21'($urandom_range(0, 32'h7F));
               2:       cp = 21'($urandom_range(32'h80, 32'h7FF));
               3:       cp = 21'($urandom_range(32'h800, 32'hFFFF));
               default: cp = 21'($urandom_range(32'h10000, 32'h10FFFF));
            endcase
            push_seq(cp, len, len);
         end else if (pick < 77) begin
            kind = $urandom_range(2);
            if (kind == 0) begin
               len = $urandom_range(2, 4);
               cp  = (len == 2) ? 21'($urandom_range(0, 32'h7F)) :
                     (len == 3) ? 21'($urandom_range(0, 32'h7FF)) :
                                  21'($urandom_range(0, 32'hFFFF));
            end else if (kind == 1) begin
               len = 3;
               cp  = 21'($urandom_range(32'hD800, 32'hDFFF));
            end else begin
               len = 4;
               cp  = 21'($urandom_range(32'h110000, 32'h1FFFFF));
            end
            push_seq(cp, len, len);
         end else if (pick < 89) begin
            len = $urandom_range(2, 4);
            cp  = 21'($urandom_range(32'h80, 32'h10FFFF));
            push_seq(cp, len, $urandom_range(1, len - 1));
         end else begin
            push_byte(8'($urandom_range(0, 255)), $urandom_range(15) == 0);
         end
      end

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (byte_queue.size() != 0 || req_bus.valid) @(posedge clock);
      while (expected_units.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      if (err_count == 0) begin
         $display("utf8_to_utf16_decoder verification clean");
      end else begin
         $display("utf8_to_utf16_decoder verification failed");
      end
      $finish;
   end

   // --------------------------------------------------------------- driver
   always @(posedge clock) begin
      if (!reset && req_bus.valid && req_bus.ready) begin
         decode_text_byte(req_bus.text_byte, req_bus.final_byte);
         sent_count++;
         byte_taken = 1;
      end
   end

   always @(negedge clock) begin
      text_item_type item;
      bit            calm;
      calm = sent_count >= 180 && sent_count < 300;
      if (reset) begin
         req_bus.valid      <= 1'b0;
         req_bus.text_byte  <= 8'h00;
         req_bus.final_byte <= 1'b0;
      end else if (!req_bus.valid || byte_taken) begin
         if (byte_queue.size() != 0 && (calm || $urandom_range(99) >= 23)) begin
            item = byte_queue.pop_front();
            req_bus.valid      <= 1'b1;
            req_bus.text_byte  <= item.text_byte;
            req_bus.final_byte <= item.final_byte;
         end else begin
            req_bus.valid      <= 1'b0;
            req_bus.text_byte  <= 8'($urandom_range(0, 255));
            req_bus.final_byte <= 1'($urandom_range(0, 1));
         end
      end
      byte_taken = 0;
   end

   // -------------------------------------------------------------- monitor
   task automatic report_mismatch(input string what, input logic [15:0] got,
                                  input logic [15:0] want);
      if (err_count < 100)
         $display("ERROR %0t: %s got %h expected %h", $realtime, what, got, want);
      err_count++;
   endtask

   always @(negedge clock) begin
      bit calm;
      calm = rcvd_count >= 200 && rcvd_count < 330;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= calm || $urandom_range(99) >= 23;
      end
   end

   always @(posedge clock) begin
      unit_rec_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         rcvd_count++;
         if (expected_units.size() == 0) begin
            report_mismatch("unexpected transaction, code_unit", rsp_bus.code_unit, 16'h0);
         end else begin
            want = expected_units.pop_front();
            if (rsp_bus.code_unit !== want.code_unit)
               report_mismatch("code_unit", rsp_bus.code_unit, want.code_unit);
            if (rsp_bus.run_end !== want.run_end)
               report_mismatch("run_end", {15'h0, rsp_bus.run_end}, {15'h0, want.run_end});
            if (rsp_bus.text_end !== want.text_end)
               report_mismatch("text_end", {15'h0, rsp_bus.text_end}, {15'h0, want.text_end});
         end
      end
   end

endmodule
